@@ design/psfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psfa_pkg;

  localparam int FOOTER_DELAY_DEPTH_DEF = 32;

  // Widths of the fixed-size fields and registers.
  localparam int BYTE_W  = 8;
  localparam int FRAME_W = 16;
  localparam int LEN_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  // A header of static plus extra length fits in one more bit than a length.
  localparam int HDR_W = LEN_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_BYTES     = 3'd0,
    CFG_STATIC_HEADER   = 3'd1,
    CFG_INITIAL_HEADER  = 3'd2,
    CFG_LATER_HEADER    = 3'd3,
    CFG_STATIC_FOOTER   = 3'd4,
    CFG_INITIAL_FOOTER  = 3'd5,
    CFG_LATER_FOOTER    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_REFUSED   = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_CLEAR = 1'b1
  } command_t;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data_byte;
    logic              packet_end;
  } in_item_t;

  typedef struct packed {
    logic               byte_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic [FRAME_W-1:0] frame_offset;
    logic               packet_done;
    status_t            status;
    logic               frame_complete;
    logic [FRAME_W-1:0] packet_count;
  } out_item_t;

  // Control for the footer delay line in one cycle.
  typedef struct packed {
    logic push;   // append the byte at the current fill position
    logic shift;  // pop the head and append the byte, fill unchanged
  } dly_ctrl_t;

endpackage

`default_nettype wire

@@ design/psfa_footer_delay.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psfa_footer_delay
  import psfa_pkg::*;
#(
  parameter int DEPTH = FOOTER_DELAY_DEPTH_DEF,
  parameter int FILL_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire dly_ctrl_t         ctrl,
  input  wire logic [FILL_W-1:0] fill,
  input  wire logic [BYTE_W-1:0] din,
  output logic      [BYTE_W-1:0] head
);

  logic [BYTE_W-1:0] entry [DEPTH];

  assign head = entry[0];

  // Each entry only ever sees its neighbor above it and the incoming byte,
  // so the line is a plain shift register with a per-entry load enable.
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    if (i < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (ctrl.push && fill == FILL_W'(i)) begin
          entry[i] <= din;
        end else if (ctrl.shift && fill == FILL_W'(i + 1)) begin
          entry[i] <= din;
        end else if (ctrl.shift && FILL_W'(i + 1) < fill) begin
          entry[i] <= entry[i + 1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (ctrl.push && fill == FILL_W'(i)) begin
          entry[i] <= din;
        end else if (ctrl.shift && fill == FILL_W'(i + 1)) begin
          entry[i] <= din;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/packet_strip_frame_assembler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Signals                          | Payload
// in      | input     | in_valid, in_ready, in_data       | in_item_t
// out     | output    | out_valid, out_ready, out_data    | out_item_t
// cfg     | input     | cfg_valid, cfg_ready, cfg_index,  | register write
//         |           | cfg_data                          |
//
// One transaction per cycle in steady state while out is not stalled; a byte is held
// in the input register and its result (if any) is loaded into the output register
// as the byte leaves it. A result stays valid there until out_ready takes it.
// Reset (rst, synchronous) clears all counters and packet state and loads the
// register defaults; the footer delay entries are not reset.
// A stall on out holds the input register and, once it is full, drops in_ready.

module packet_strip_frame_assembler_core
  import psfa_pkg::*;
#(
  parameter int FOOTER_DELAY_DEPTH = FOOTER_DELAY_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FILL_W = $clog2(FOOTER_DELAY_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > HDR_W) ? FILL_W : HDR_W;

  // Configuration registers.
  logic [FRAME_W-1:0] frame_bytes;
  logic [LEN_W-1:0]   static_header_len, initial_header_len, later_header_len;
  logic [LEN_W-1:0]   static_footer_len, initial_footer_len, later_footer_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes        <= '1;
      static_header_len  <= '0;
      initial_header_len <= '0;
      later_header_len   <= '0;
      static_footer_len  <= '0;
      initial_footer_len <= '0;
      later_footer_len   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_BYTES:    frame_bytes        <= cfg_data;
        CFG_STATIC_HEADER:  static_header_len  <= cfg_data[LEN_W-1:0];
        CFG_INITIAL_HEADER: initial_header_len <= cfg_data[LEN_W-1:0];
        CFG_LATER_HEADER:   later_header_len   <= cfg_data[LEN_W-1:0];
        CFG_STATIC_FOOTER:  static_footer_len  <= cfg_data[LEN_W-1:0];
        CFG_INITIAL_FOOTER: initial_footer_len <= cfg_data[LEN_W-1:0];
        CFG_LATER_FOOTER:   later_footer_len   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic     s1_valid;
  in_item_t s1_data;
  logic     s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Frame and packet state.
  logic [FRAME_W-1:0] frame_fill, frame_fill_next;
  logic               done_flag, done_flag_next;
  logic [FRAME_W-1:0] accepted_packets, accepted_packets_next;
  logic [HDR_W-1:0]   byte_position, byte_position_next;
  logic [FILL_W-1:0]  delay_fill, delay_fill_next;
  logic               first_packet_mode, first_packet_mode_next;
  logic               packet_refused, packet_refused_next;
  logic               packet_truncated, packet_truncated_next;
  logic               in_packet, in_packet_next;

  dly_ctrl_t          dly_ctrl;
  logic [BYTE_W-1:0]  dly_head;

  logic               produce;
  out_item_t          result;

  logic               fpm, refused;
  logic [HDR_W-1:0]   hdr;
  logic [HDR_W-1:0]   ftr_raw;
  logic [CMP_W-1:0]   ftr;
  logic               emerge;
  logic [BYTE_W-1:0]  payload;

  always_comb begin
    frame_fill_next        = frame_fill;
    done_flag_next         = done_flag;
    accepted_packets_next  = accepted_packets;
    byte_position_next     = byte_position;
    delay_fill_next        = delay_fill;
    first_packet_mode_next = first_packet_mode;
    packet_refused_next    = packet_refused;
    packet_truncated_next  = packet_truncated;
    in_packet_next         = in_packet;
    dly_ctrl               = '0;
    produce                = 1'b0;
    result                 = '0;
    emerge                 = 1'b0;
    payload                = '0;

    // Packet start decisions are taken from the state before this byte.
    fpm     = in_packet ? first_packet_mode : (frame_fill == '0);
    refused = in_packet ? packet_refused : (done_flag || frame_fill >= frame_bytes);

    hdr     = HDR_W'(static_header_len) +
              HDR_W'(fpm ? initial_header_len : later_header_len);
    ftr_raw = HDR_W'(static_footer_len) +
              HDR_W'(fpm ? initial_footer_len : later_footer_len);
    ftr     = (CMP_W'(ftr_raw) > CMP_W'(FOOTER_DELAY_DEPTH)) ?
              CMP_W'(FOOTER_DELAY_DEPTH) : CMP_W'(ftr_raw);

    if (s1_fire) begin
      if (command_t'(s1_data.command) == CMD_CLEAR) begin
        frame_fill_next       = '0;
        done_flag_next        = 1'b0;
        accepted_packets_next = '0;
        byte_position_next    = '0;
        delay_fill_next       = '0;
        packet_refused_next   = 1'b0;
        packet_truncated_next = 1'b0;
        in_packet_next        = 1'b0;
      end else begin
        in_packet_next         = 1'b1;
        first_packet_mode_next = fpm;
        packet_refused_next    = refused;

        if (!refused) begin
          if (byte_position < hdr) begin
            byte_position_next = byte_position + 1'b1;
          end else if (CMP_W'(delay_fill) >= ftr) begin
            emerge = 1'b1;
            if (delay_fill == '0) begin
              payload = s1_data.data_byte;
            end else begin
              payload        = dly_head;
              dly_ctrl.shift = 1'b1;
            end
          end else begin
            dly_ctrl.push   = 1'b1;
            delay_fill_next = delay_fill + 1'b1;
          end

          if (emerge) begin
            if (frame_fill < frame_bytes) begin
              result.byte_valid   = 1'b1;
              result.out_byte     = payload;
              result.frame_offset = frame_fill;
              frame_fill_next     = frame_fill + 1'b1;
              if (frame_fill_next >= frame_bytes) begin
                done_flag_next = 1'b1;
              end
            end else begin
              packet_truncated_next = 1'b1;
              done_flag_next        = 1'b1;
            end
          end
        end

        if (s1_data.packet_end) begin
          result.packet_done = 1'b1;
          if (refused) begin
            result.status = STAT_REFUSED;
          end else begin
            if (byte_position_next < hdr || CMP_W'(delay_fill_next) < ftr) begin
              result.status = STAT_UNDERFLOW;
            end else if (packet_truncated_next) begin
              result.status = STAT_TRUNCATED;
            end else begin
              result.status = STAT_OK;
            end
            accepted_packets_next = accepted_packets + 1'b1;
          end
          byte_position_next    = '0;
          delay_fill_next       = '0;
          packet_refused_next   = 1'b0;
          packet_truncated_next = 1'b0;
          in_packet_next        = 1'b0;
        end

        produce               = result.byte_valid || s1_data.packet_end;
        result.frame_complete = (frame_fill_next >= frame_bytes);
        result.packet_count   = accepted_packets_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_fill        <= '0;
      done_flag         <= 1'b0;
      accepted_packets  <= '0;
      byte_position     <= '0;
      delay_fill        <= '0;
      first_packet_mode <= 1'b1;
      packet_refused    <= 1'b0;
      packet_truncated  <= 1'b0;
      in_packet         <= 1'b0;
    end else begin
      frame_fill        <= frame_fill_next;
      done_flag         <= done_flag_next;
      accepted_packets  <= accepted_packets_next;
      byte_position     <= byte_position_next;
      delay_fill        <= delay_fill_next;
      first_packet_mode <= first_packet_mode_next;
      packet_refused    <= packet_refused_next;
      packet_truncated  <= packet_truncated_next;
      in_packet         <= in_packet_next;
    end
  end

  psfa_footer_delay #(
    .DEPTH  (FOOTER_DELAY_DEPTH),
    .FILL_W (FILL_W)
  ) u_delay (
    .clk  (clk),
    .ctrl (dly_ctrl),
    .fill (delay_fill),
    .din  (s1_data.data_byte),
    .head (dly_head)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= produce;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && produce) begin
      out_data <= result;
    end
  end

  // The delay line never holds more bytes than it has entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(delay_fill) <= CMP_W'(FOOTER_DELAY_DEPTH))
    else $error("footer delay fill exceeds depth");

  // Between packets no header or footer progress may linger.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !in_packet |-> (byte_position == '0 && delay_fill == '0 && !packet_truncated))
    else $error("packet state left over outside a packet");

  // A result without a payload byte is always the end of a packet.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.byte_valid || out_data.packet_done))
    else $error("empty result issued");

  // Status is only reported on the last byte of a packet.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.packet_done) |-> out_data.status == STAT_OK)
    else $error("status without packet end");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
  import psfa_pkg::*;
();

  localparam int DLY_DEPTH     = FOOTER_DELAY_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_PHASES    = 8;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    cfg_reg_t     reg_idx;
    logic [15:0]  value;
    in_item_t     item;
    bit           given;
    out_item_t    want;
  } stim_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Sideband that travels with each input transaction: a typed-in expectation.
  bit        row_given = 1'b0;
  out_item_t row_want = '0;

  int in_idle_pct  = 32;
  int out_idle_pct = 32;

  // Predictor copy of the registers.
  int frame_limit = 65535;
  int hdr_static = 0;
  int hdr_first  = 0;
  int hdr_later  = 0;
  int ftr_static = 0;
  int ftr_first  = 0;
  int ftr_later  = 0;

  // Predictor copy of the frame and packet state.
  int          placed_bytes = 0;
  bit          frame_closed = 1'b0;
  logic [15:0] packets_taken = '0;
  int          hdr_seen = 0;
  logic [7:0]  dly_line [DLY_DEPTH];
  int          dly_used = 0;
  bit          first_of_frame = 1'b1;
  bit          refusing = 1'b0;
  bit          cut_short = 1'b0;
  bit          mid_packet = 1'b0;

  out_item_t awaited_results [$];

  int mismatches = 0;
  int results_checked = 0;
  int bytes_taken = 0;
  int clears_taken = 0;
  int settings_used = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int quiet_cycles = 0;

  packet_strip_frame_assembler_core #(
    .FOOTER_DELAY_DEPTH(DLY_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic void drop_packet_state();
    hdr_seen = 0;
    dly_used = 0;
    refusing = 1'b0;
    cut_short = 1'b0;
    mid_packet = 1'b0;
  endfunction

  // Advances the predicted state by one link byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input in_item_t it, output out_item_t res);
    int         hdr;
    int         ftr;
    int         n;
    int         i;
    bit         emerge;
    bit         placed;
    logic [7:0] payload;
    res = '0;
    emerge = 1'b0;
    placed = 1'b0;
    payload = '0;
    if (it.command == CMD_CLEAR) begin
      placed_bytes = 0;
      frame_closed = 1'b0;
      packets_taken = '0;
      drop_packet_state();
      return 1'b0;
    end
    if (!mid_packet) begin
      mid_packet = 1'b1;
      first_of_frame = (placed_bytes == 0);
      refusing = frame_closed || (placed_bytes >= frame_limit);
    end
    hdr = hdr_static + (first_of_frame ? hdr_first : hdr_later);
    ftr = ftr_static + (first_of_frame ? ftr_first : ftr_later);
    if (ftr > DLY_DEPTH) ftr = DLY_DEPTH;
    if (!refusing) begin
      if (hdr_seen < hdr) begin
        hdr_seen++;
      end else begin
        if (dly_used >= ftr) begin
          emerge = 1'b1;
          if (dly_used == 0) begin
            payload = it.data_byte;
          end else begin
            // The footer shrank or stayed put: the oldest held byte leaves.
            n = (dly_used > DLY_DEPTH) ? DLY_DEPTH : dly_used;
            payload = dly_line[0];
            for (i = 0; i < n - 1; i++) dly_line[i] = dly_line[i + 1];
            dly_line[n - 1] = it.data_byte;
          end
        end else begin
          dly_line[dly_used] = it.data_byte;
          dly_used++;
        end
        if (emerge) begin
          if (placed_bytes < frame_limit) begin
            placed = 1'b1;
            res.out_byte = payload;
            res.frame_offset = placed_bytes[15:0];
            placed_bytes++;
            if (placed_bytes >= frame_limit) frame_closed = 1'b1;
          end else begin
            cut_short = 1'b1;
            frame_closed = 1'b1;
          end
        end
      end
    end
    if (it.packet_end) begin
      if (refusing) begin
        res.status = STAT_REFUSED;
      end else begin
        if (hdr_seen < hdr || dly_used < ftr) res.status = STAT_UNDERFLOW;
        else if (cut_short) res.status = STAT_TRUNCATED;
        else res.status = STAT_OK;
        packets_taken = packets_taken + 16'd1;
      end
      drop_packet_state();
    end
    if (!placed && !it.packet_end) return 1'b0;
    res.byte_valid = placed;
    res.packet_done = it.packet_end;
    res.frame_complete = (placed_bytes >= frame_limit);
    res.packet_count = packets_taken;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
             what, got_v, want_v, results_checked);
    mismatches++;
  endtask

  // Checks results, then tracks register writes and accepted bytes in the predictor.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    out_item_t res;
    bit        produced;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", 0, 0);
        end else begin
          want = awaited_results.pop_front();
          if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
          if (got.frame_offset !== want.frame_offset)
            report_mismatch("frame_offset", int'(got.frame_offset),
                            int'(want.frame_offset));
          if (got.packet_done !== want.packet_done)
            report_mismatch("packet_done", int'(got.packet_done), int'(want.packet_done));
          if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
          if (got.frame_complete !== want.frame_complete)
            report_mismatch("frame_complete", int'(got.frame_complete),
                            int'(want.frame_complete));
          if (got.packet_count !== want.packet_count)
            report_mismatch("packet_count", int'(got.packet_count),
                            int'(want.packet_count));
          if (want.packet_done) status_seen[int'(want.status)]++;
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_FRAME_BYTES:    frame_limit = int'(cfg_data);
          CFG_STATIC_HEADER:  hdr_static  = int'(cfg_data[LEN_W-1:0]);
          CFG_INITIAL_HEADER: hdr_first   = int'(cfg_data[LEN_W-1:0]);
          CFG_LATER_HEADER:   hdr_later   = int'(cfg_data[LEN_W-1:0]);
          CFG_STATIC_FOOTER:  ftr_static  = int'(cfg_data[LEN_W-1:0]);
          CFG_INITIAL_FOOTER: ftr_first   = int'(cfg_data[LEN_W-1:0]);
          CFG_LATER_FOOTER:   ftr_later   = int'(cfg_data[LEN_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        bytes_taken++;
        if (in_data.command == CMD_CLEAR) clears_taken++;
        produced = deframe_byte(in_data, res);
        if (row_given) awaited_results = {awaited_results, row_want};
        else if (produced) awaited_results = {awaited_results, res};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it, bit given, out_item_t want);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_given <= given;
    row_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_packet(int n);
    in_item_t it;
    int       k;
    for (k = 0; k < n; k++) begin
      it.command = CMD_DATA;
      it.data_byte = 8'($urandom_range(255));
      it.packet_end = (k == n - 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic send_clear();
    in_item_t it;
    it.command = CMD_CLEAR;
    it.data_byte = 8'($urandom_range(255));
    it.packet_end = 1'($urandom_range(1));
    send_item(it, 1'b0, '0);
  endtask

  // Waits until every awaited result is in and bytes with no result have drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [3:0] pick_len();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'd15;
    return 4'($urandom_range(15));
  endfunction

  task automatic random_phase(int phase, int budget);
    logic [15:0] fb;
    logic [3:0]  lens [6];
    int          j;
    int          sent;
    int          hdr;
    int          ftr;
    int          plen;
    int          r;
    wait_idle();
    case (phase)
      0: begin
        fb = 16'hFFFF;
        foreach (lens[j]) lens[j] = 4'd15;
      end
      1: begin
        fb = 16'd1;
        foreach (lens[j]) lens[j] = 4'd0;
      end
      2: begin
        fb = 16'd0;
        foreach (lens[j]) lens[j] = pick_len();
      end
      default: begin
        fb = 16'($urandom_range(1, 24));
        foreach (lens[j]) lens[j] = pick_len();
      end
    endcase
    // One stretch runs with both sides always ready to transfer.
    in_idle_pct = (phase == 3) ? 0 : 32;
    out_idle_pct = (phase == 3) ? 0 : 32;
    write_reg(CFG_FRAME_BYTES, fb);
    for (j = 0; j < 6; j++) write_reg(cfg_reg_t'(j + 1), {12'd0, lens[j]});
    settings_used++;
    sent = 0;
    while (sent < budget) begin
      hdr = int'(lens[0]) + ((placed_bytes == 0) ? int'(lens[1]) : int'(lens[2]));
      ftr = int'(lens[3]) + ((placed_bytes == 0) ? int'(lens[4]) : int'(lens[5]));
      r = $urandom_range(99);
      if (r < 6 || (frame_closed && r < 40)) begin
        send_clear();
        sent++;
      end else begin
        if (r < 85) plen = hdr + ftr + int'($urandom_range(0, 6));
        else plen = int'($urandom_range(1, hdr + ftr + 1));
        if (plen < 1) plen = 1;
        send_packet(plen);
        sent += plen;
      end
    end
  endtask

  function automatic out_item_t outcome(bit v, logic [7:0] b, logic [15:0] off, bit done,
                                        status_t st, bit full, logic [15:0] cnt);
    out_item_t o;
    o.byte_valid = v;
    o.out_byte = b;
    o.frame_offset = off;
    o.packet_done = done;
    o.status = st;
    o.frame_complete = full;
    o.packet_count = cnt;
    return o;
  endfunction

  function automatic stim_row_t byte_row(command_t cmd, logic [7:0] b, bit last);
    stim_row_t row;
    row.kind = ROW_BYTE;
    row.reg_idx = CFG_FRAME_BYTES;
    row.value = '0;
    row.item.command = cmd;
    row.item.data_byte = b;
    row.item.packet_end = last;
    row.given = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [7:0] b, bit last, out_item_t want);
    stim_row_t row;
    row = byte_row(CMD_DATA, b, last);
    row.given = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_t r, logic [15:0] v);
    stim_row_t row;
    row = byte_row(CMD_DATA, 8'h00, 1'b0);
    row.kind = ROW_CFG;
    row.reg_idx = r;
    row.value = v;
    return row;
  endfunction

  initial begin
    stim_row_t directed [$];
    bit        settled;
    int        p;
    // Reset defaults: nothing stripped, the byte passes straight into the frame.
    directed = {directed, known_row(8'hFF, 1'b1, outcome(1, 8'hFF, 0, 1, STAT_OK, 0, 1))};
    directed = {directed, byte_row(CMD_CLEAR, 8'h5A, 1'b1)};
    directed = {directed, cfg_row(CFG_FRAME_BYTES, 16'd3)};
    directed = {directed, cfg_row(CFG_STATIC_HEADER, 16'd1)};
    directed = {directed, cfg_row(CFG_INITIAL_HEADER, 16'd1)};
    directed = {directed, cfg_row(CFG_LATER_HEADER, 16'd2)};
    directed = {directed, cfg_row(CFG_STATIC_FOOTER, 16'd1)};
    directed = {directed, cfg_row(CFG_INITIAL_FOOTER, 16'd1)};
    directed = {directed, cfg_row(CFG_LATER_FOOTER, 16'd0)};
    // First packet of the frame: two header and two footer bytes.
    directed = {directed, byte_row(CMD_DATA, 8'h00, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h11, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h22, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h33, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h44, 1'b1)};
    // Later packet: three header bytes and one footer byte.
    directed = {directed, byte_row(CMD_DATA, 8'h01, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h02, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h03, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h80, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h7F, 1'b1)};
    // Too short for its header: underflow.
    directed = {directed, byte_row(CMD_DATA, 8'hAA, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h55, 1'b1)};
    // Fills the frame and then overruns it: truncated.
    directed = {directed, byte_row(CMD_DATA, 8'h10, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h20, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h40, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'hC3, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h3C, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'hE7, 1'b1)};
    // The frame is done, so the next packet is refused.
    directed = {directed, known_row(8'h99, 1'b1,
                                    outcome(0, 8'h00, 0, 1, STAT_REFUSED, 1, 4))};
    directed = {directed, byte_row(CMD_CLEAR, 8'hA5, 1'b0)};
    // Footer length shrinks in the middle of a packet.
    directed = {directed, byte_row(CMD_DATA, 8'h30, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h31, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h32, 1'b0)};
    directed = {directed, byte_row(CMD_DATA, 8'h33, 1'b0)};
    directed = {directed, cfg_row(CFG_STATIC_FOOTER, 16'd0)};
    directed = {directed, byte_row(CMD_DATA, 8'h34, 1'b1)};
    // A zero-size frame counts as full from the start.
    directed = {directed, cfg_row(CFG_FRAME_BYTES, 16'd0)};
    directed = {directed, known_row(8'h80, 1'b1,
                                    outcome(0, 8'h00, 0, 1, STAT_REFUSED, 1, 1))};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    settled = 1'b0;
    foreach (directed[p]) begin
      if (directed[p].kind == ROW_CFG) begin
        if (!settled) begin
          wait_idle();
          settings_used++;
        end
        settled = 1'b1;
        write_reg(directed[p].reg_idx, directed[p].value);
      end else begin
        settled = 1'b0;
        send_item(directed[p].item, directed[p].given, directed[p].want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) random_phase(p, (p == 0) ? 100 : 40);

    wait_idle();
    $display("Covered %0d link bytes (%0d clears) under %0d register settings; %0d results compared.",
             bytes_taken, clears_taken, settings_used, results_checked);
    $display("Packet endings: %0d ok, %0d refused, %0d underflow, %0d truncated.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/psfa_pkg.sv
design/psfa_footer_delay.sv
design/packet_strip_frame_assembler_core.sv
tb/sv/tb_top.sv
